### hdl/dws_pkg.sv
// Package for the dictionary word segmenter: opcodes, record kinds and fixed constants.
// No dependencies; used by the top level dictionary_word_segmenter.
package dws_pkg;

   // Input opcodes.
   localparam logic [1:0] OP_CHAR  = 2'd0;
   localparam logic [1:0] OP_CHILD = 2'd1;
   localparam logic [1:0] OP_NODE  = 2'd2;

   // Result record kinds.
   localparam logic [1:0] KIND_WORD  = 2'd0;
   localparam logic [1:0] KIND_SKIP  = 2'd1;
   localparam logic [1:0] KIND_EMPTY = 2'd2;

   // Alphabet of the automaton and letter bounds.
   localparam int ALPHABET = 26;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;

   // Controller states, one-hot.
   typedef enum logic [7:0] {
      ST_CLEAR = 8'b0000_0001,
      ST_IDLE  = 8'b0000_0010,
      ST_CHILD = 8'b0000_0100,
      ST_FAIL  = 8'b0000_1000,
      ST_SUF   = 8'b0001_0000,
      ST_LONG  = 8'b0010_0000,
      ST_LINE  = 8'b0100_0000,
      ST_EMIT  = 8'b1000_0000
   } state_type;

endpackage

### hdl/dictionary_word_segmenter.sv
// Top level of the dictionary word segmenter: Aho-Corasick walk over table memories.
// Depends on dws_pkg and dws_ram.
//
//  channel   ports                      handshake
//  request   req_* fields               accepted when start is high and busy is low
//  response  rsp_* fields, rsp_valid    one-cycle strobe, no back pressure
//
// A table write is taken in ST_IDLE, which the controller does not leave for it. A text
// letter goes through the child lookup (ST_CHILD), then ST_FAIL and ST_CHILD again per failure
// link followed, ST_SUF per node visited on the suffix chain and ST_LONG for each word length
// checked against the longest-word store, all set by the single read port of the child and node
// memories. A line end emits one record per cycle after a setup state, ST_LINE. After reset a
// clearing pass zeroes the child and node tables while busy stays high. The receiver cannot stall.
module dictionary_word_segmenter #(
   parameter int NODE_COUNT = 1024,
   parameter int LINE_MAX   = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_op,
   input  logic [9:0] req_node_id,
   input  logic [4:0] req_symbol,
   input  logic [9:0] req_child_node,
   input  logic [9:0] req_fail_link,
   input  logic [9:0] req_suffix_node,
   input  logic [7:0] req_word_length,
   input  logic [7:0] req_text_char,
   input  logic       req_has_char,
   input  logic       req_line_end,
   output logic       rsp_valid,
   output logic [1:0] rsp_kind,
   output logic [5:0] rsp_start_pos,
   output logic [6:0] rsp_seg_length,
   output logic [7:0] rsp_skipped_char,
   output logic [6:0] rsp_skip_count,
   output logic       rsp_overflowed,
   output logic       rsp_last
);
   import dws_pkg::*;

   localparam int NW          = $clog2(NODE_COUNT);
   localparam int CHILD_DEPTH = NODE_COUNT * ALPHABET;
   localparam int CAW         = $clog2(CHILD_DEPTH);
   localparam int SW          = $clog2(NODE_COUNT + 1);
   localparam int LAW         = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
   localparam int NDW         = 2 * NW + 8;

   // Child address of a node and a letter.
   function automatic logic [CAW-1:0] child_addr(input logic [NW-1:0] node,
                                                 input logic [4:0] sym);
      return CAW'(CAW'(node) * CAW'(ALPHABET) + CAW'(sym));
   endfunction

   state_type state_ff, state_in;
   logic [NW-1:0]  cur_ff, cur_in;
   logic [NW-1:0]  node_ff, node_in;
   logic [4:0]     sym_ff, sym_in;
   logic [SW-1:0]  steps_ff, steps_in;
   logic [6:0]     lp_ff, lp_in;
   logic           ovf_ff, ovf_in;
   logic           pend_ff, pend_in;
   logic [6:0]     len_ff, len_in;
   logic [LAW-1:0] lstart_ff, lstart_in;
   logic [6:0]     pos_ff, pos_in;
   logic [6:0]     skips_ff, skips_in;
   logic [CAW-1:0] clr_ff, clr_in;
   logic [LINE_MAX-1:0] valid_ff, valid_in;
   logic           lgv_ff;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_kind_ff, rsp_kind_in;
   logic [5:0] rsp_start_ff, rsp_start_in;
   logic [6:0] rsp_len_ff, rsp_len_in;
   logic [7:0] rsp_char_ff, rsp_char_in;
   logic [6:0] rsp_skips_ff, rsp_skips_in;
   logic       rsp_ovf_ff, rsp_ovf_in;
   logic       rsp_last_ff, rsp_last_in;

   // Memory ports.
   logic           ch_we;
   logic [CAW-1:0] ch_waddr, ch_raddr;
   logic [NW-1:0]  ch_wdata, ch_rdata;
   logic           nd_we;
   logic [NW-1:0]  nd_waddr, nd_raddr;
   logic [NDW-1:0] nd_wdata, nd_rdata;
   logic           ln_we;
   logic [LAW-1:0] ln_waddr, ln_raddr;
   logic [7:0]     ln_rdata;
   logic           lg_we;
   logic [LAW-1:0] lg_raddr;
   logic [6:0]     lg_rdata;

   dws_ram #(.WIDTH(NW), .DEPTH(CHILD_DEPTH)) u_child (
      .clock(clock), .we(ch_we), .waddr(ch_waddr), .wdata(ch_wdata),
      .raddr(ch_raddr), .rdata(ch_rdata));
   dws_ram #(.WIDTH(NDW), .DEPTH(NODE_COUNT)) u_node (
      .clock(clock), .we(nd_we), .waddr(nd_waddr), .wdata(nd_wdata),
      .raddr(nd_raddr), .rdata(nd_rdata));
   dws_ram #(.WIDTH(8), .DEPTH(LINE_MAX)) u_line (
      .clock(clock), .we(ln_we), .waddr(ln_waddr), .wdata(req_text_char),
      .raddr(ln_raddr), .rdata(ln_rdata));
   dws_ram #(.WIDTH(7), .DEPTH(LINE_MAX)) u_longest (
      .clock(clock), .we(lg_we), .waddr(lstart_ff), .wdata(len_ff),
      .raddr(lg_raddr), .rdata(lg_rdata));

   // Request decoding and character folding.
   logic          accept, node_ok, letter;
   logic [7:0]    folded;
   logic [4:0]    char_sym;
   logic [NW-1:0] clip_child, clip_fail, clip_suffix;

   assign accept  = start && (state_ff == ST_IDLE);
   assign node_ok = (17'(req_node_id) < 17'(NODE_COUNT));
   assign folded  = (req_text_char >= CHAR_UPPER_A && req_text_char <= CHAR_UPPER_Z) ?
                    (req_text_char | 8'h20) : req_text_char;
   assign letter  = (folded >= CHAR_LOWER_A) && (folded <= CHAR_LOWER_Z);
   assign char_sym = 5'(folded - CHAR_LOWER_A);
   assign clip_child  = (17'(req_child_node) < 17'(NODE_COUNT)) ? NW'(req_child_node) : '0;
   assign clip_fail   = (17'(req_fail_link) < 17'(NODE_COUNT)) ? NW'(req_fail_link) : '0;
   assign clip_suffix = (17'(req_suffix_node) < 17'(NODE_COUNT)) ? NW'(req_suffix_node) : '0;

   // Node table fields.
   logic [NW-1:0] rd_fail, rd_suffix;
   logic [7:0]    rd_len;
   assign rd_fail   = nd_rdata[NDW-1 -: NW];
   assign rd_suffix = nd_rdata[8 +: NW];
   assign rd_len    = nd_rdata[7:0];

   // Emission helpers.
   logic [6:0] em_len, em_next;
   assign em_len  = lgv_ff ? lg_rdata : 7'd0;
   assign em_next = pos_ff + ((em_len != 7'd0) ? em_len : 7'd1);

   // Controller.
   always_comb begin
      logic done;
      logic clear_line;
      logic [SW-1:0] steps_inc;
      done         = 1'b0;
      clear_line   = 1'b0;
      steps_inc    = steps_ff + SW'(1);
      state_in     = state_ff;
      cur_in       = cur_ff;
      node_in      = node_ff;
      sym_in       = sym_ff;
      steps_in     = steps_ff;
      lp_in        = lp_ff;
      ovf_in       = ovf_ff;
      pend_in      = pend_ff;
      len_in       = len_ff;
      lstart_in    = lstart_ff;
      pos_in       = pos_ff;
      skips_in     = skips_ff;
      clr_in       = clr_ff;
      valid_in     = valid_ff;
      rsp_valid_in = 1'b0;
      rsp_kind_in  = rsp_kind_ff;
      rsp_start_in = rsp_start_ff;
      rsp_len_in   = rsp_len_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_skips_in = rsp_skips_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_last_in  = 1'b0;
      ch_we        = 1'b0;
      ch_waddr     = child_addr(NW'(req_node_id), req_symbol);
      ch_wdata     = clip_child;
      ch_raddr     = child_addr(rd_fail, sym_ff);
      nd_we        = 1'b0;
      nd_waddr     = NW'(req_node_id);
      nd_wdata     = {clip_fail, clip_suffix, req_word_length};
      nd_raddr     = node_ff;
      ln_we        = 1'b0;
      ln_waddr     = lp_ff[LAW-1:0];
      ln_raddr     = em_next[LAW-1:0];
      lg_we        = 1'b0;
      lg_raddr     = em_next[LAW-1:0];

      case (state_ff)
         // Zero the child and node tables after reset.
         ST_CLEAR: begin
            ch_we    = 1'b1;
            ch_waddr = clr_ff;
            ch_wdata = '0;
            nd_we    = (32'(clr_ff) < NODE_COUNT);
            nd_waddr = clr_ff[NW-1:0];
            nd_wdata = '0;
            clr_in   = clr_ff + CAW'(1);
            if (32'(clr_ff) == CHILD_DEPTH - 1) begin
               state_in = ST_IDLE;
            end
         end
         // Take table writes and text characters.
         ST_IDLE: begin
            ch_raddr = child_addr(cur_ff, char_sym);
            if (accept) begin
               case (req_op)
                  OP_CHILD: ch_we = node_ok && (req_symbol < 5'(ALPHABET));
                  OP_NODE:  nd_we = node_ok;
                  OP_CHAR: begin
                     pend_in = req_line_end;
                     if (req_has_char && (32'(lp_ff) >= LINE_MAX)) begin
                        ovf_in = 1'b1;
                        state_in = req_line_end ? ST_LINE : ST_IDLE;
                     end else if (req_has_char) begin
                        ln_we = 1'b1;
                        lp_in = lp_ff + 7'd1;
                        if (letter) begin
                           node_in  = cur_ff;
                           sym_in   = char_sym;
                           steps_in = '0;
                           state_in = ST_CHILD;
                        end else begin
                           cur_in   = '0;
                           state_in = req_line_end ? ST_LINE : ST_IDLE;
                        end
                     end else begin
                        state_in = req_line_end ? ST_LINE : ST_IDLE;
                     end
                  end
                  default: ;
               endcase
            end
         end
         // Child entry of the walk node is available.
         ST_CHILD: begin
            if (32'(steps_ff) >= NODE_COUNT) begin
               cur_in = '0;
               done   = 1'b1;
            end else if (ch_rdata != '0) begin
               cur_in   = ch_rdata;
               node_in  = ch_rdata;
               steps_in = '0;
               nd_raddr = ch_rdata;
               state_in = ST_SUF;
            end else if (node_ff == '0) begin
               cur_in = '0;
               done   = 1'b1;
            end else begin
               nd_raddr = node_ff;
               state_in = ST_FAIL;
            end
         end
         // Follow the failure link and look up its child.
         ST_FAIL: begin
            node_in  = rd_fail;
            steps_in = steps_inc;
            state_in = ST_CHILD;
         end
         // Word length and suffix link of the walk node are available.
         ST_SUF: begin
            node_in  = rd_suffix;
            steps_in = steps_inc;
            if (rd_len != 8'd0 && rd_len <= 8'(lp_ff)) begin
               len_in    = 7'(rd_len);
               lstart_in = LAW'(lp_ff - 7'(rd_len));
               lg_raddr  = LAW'(lp_ff - 7'(rd_len));
               state_in  = ST_LONG;
            end else if (rd_suffix != '0 && 32'(steps_inc) < NODE_COUNT) begin
               nd_raddr = rd_suffix;
            end else begin
               done = 1'b1;
            end
         end
         // Keep the longer word for this start position.
         ST_LONG: begin
            if (len_ff > (lgv_ff ? lg_rdata : 7'd0)) begin
               lg_we = 1'b1;
               valid_in[lstart_ff] = 1'b1;
            end
            if (node_ff != '0 && 32'(steps_ff) < NODE_COUNT) begin
               state_in = ST_SUF;
            end else begin
               done = 1'b1;
            end
         end
         // Start the emission of the line.
         ST_LINE: begin
            ln_raddr = '0;
            lg_raddr = '0;
            pos_in   = 7'd0;
            skips_in = 7'd0;
            if (lp_ff == 7'd0) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_EMPTY;
               rsp_start_in = 6'd0;
               rsp_len_in   = 7'd0;
               rsp_char_in  = 8'd0;
               rsp_skips_in = 7'd0;
               rsp_ovf_in   = ovf_ff;
               rsp_last_in  = 1'b1;
               clear_line   = 1'b1;
            end else begin
               state_in = ST_EMIT;
            end
         end
         // One segment record per cycle.
         ST_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_start_in = 6'(pos_ff);
            rsp_ovf_in   = ovf_ff;
            rsp_last_in  = (em_next >= lp_ff);
            if (em_len != 7'd0) begin
               rsp_kind_in  = KIND_WORD;
               rsp_len_in   = em_len;
               rsp_char_in  = 8'd0;
               rsp_skips_in = skips_ff;
            end else begin
               rsp_kind_in  = KIND_SKIP;
               rsp_len_in   = 7'd1;
               rsp_char_in  = ln_rdata;
               rsp_skips_in = skips_ff + 7'd1;
               skips_in     = skips_ff + 7'd1;
            end
            pos_in = em_next;
            if (em_next >= lp_ff) begin
               clear_line = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (done) begin
         state_in = pend_ff ? ST_LINE : ST_IDLE;
      end
      if (clear_line) begin
         valid_in = '0;
         lp_in    = 7'd0;
         ovf_in   = 1'b0;
         cur_in   = '0;
         pend_in  = 1'b0;
         state_in = ST_IDLE;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cur_ff       <= '0;
         lp_ff        <= '0;
         ovf_ff       <= 1'b0;
         pend_ff      <= 1'b0;
         clr_ff       <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         lp_ff        <= lp_in;
         ovf_ff       <= ovf_in;
         pend_ff      <= pend_in;
         clr_ff       <= clr_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      node_ff      <= node_in;
      sym_ff       <= sym_in;
      steps_ff     <= steps_in;
      len_ff       <= len_in;
      lstart_ff    <= lstart_in;
      pos_ff       <= pos_in;
      skips_ff     <= skips_in;
      lgv_ff       <= valid_in[lg_raddr] & valid_ff[lg_raddr];
      rsp_kind_ff  <= rsp_kind_in;
      rsp_start_ff <= rsp_start_in;
      rsp_len_ff   <= rsp_len_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_skips_ff <= rsp_skips_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_start_pos    = rsp_start_ff;
   assign rsp_seg_length   = rsp_len_ff;
   assign rsp_skipped_char = rsp_char_ff;
   assign rsp_skip_count   = rsp_skips_ff;
   assign rsp_overflowed   = rsp_ovf_ff;
   assign rsp_last         = rsp_last_ff;

   // The line position never passes the line capacity.
   a_lp_bound: assert property (@(posedge clock) disable iff (reset)
      32'(lp_ff) <= LINE_MAX) else $error("line position past capacity");

   // The final record of a line is followed by no record.
   a_last_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |=> !rsp_valid_ff) else $error("record after last");

   // An empty line holds no recorded words.
   a_empty_clean: assert property (@(posedge clock) disable iff (reset)
      (lp_ff == 7'd0) |-> (valid_ff == '0)) else $error("stale word in empty line");

   // Records come only while the line is being emitted or has just finished.
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(state_ff) == ST_EMIT || $past(state_ff) == ST_LINE))
      else $error("record outside emission");
endmodule

### hdl/dws_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
module dws_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                             clock,
   input  logic                             we,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
   input  logic [WIDTH-1:0]                 wdata,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
   output logic [WIDTH-1:0]                 rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
